// ===== rtl/core/pdc_pkg.sv =====
// pdc_pkg: shared types and constants of the pid dac controller
// no dependencies; imported by every module of the block
package pdc_pkg;

    // sample and gain format
    localparam int SAMPLE_BITS    = 12;
    localparam int GAIN_FRAC_BITS = 24;
    localparam int GAIN_W         = 32;
    localparam int DAC_W          = 15;

    // derived datapath widths
    localparam int ERR_W  = SAMPLE_BITS + 1;
    localparam int DIFF_W = ERR_W + 1;
    localparam int SUM_W  = 32;
    localparam int PT_W   = GAIN_W + ERR_W;
    localparam int IT_W   = GAIN_W + SUM_W;
    localparam int DT_W   = GAIN_W + DIFF_W;
    localparam int ACC_W  = 64;
    localparam int SH_W   = ACC_W - GAIN_FRAC_BITS;
    localparam int DRV_W  = SH_W + 1;

    // output word constants
    localparam logic [DAC_W-1:0]       DAC_CTRL  = 15'h7000;
    localparam logic [SAMPLE_BITS-1:0] MAX_CODE  = {SAMPLE_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] MIN_CODE  = '0;
    localparam logic [DRV_W-1:0]       MID_SCALE = DRV_W'(1) << (SAMPLE_BITS - 1);

    // saturation limits of the error sum
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 32'd46137344;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 32'd7;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 32'd0;

    // input request
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ref_sample;
        logic [SAMPLE_BITS-1:0] meas_sample;
    } pdc_in_t;

    // result request
    typedef struct packed {
        logic [DAC_W-1:0] dac_word;
        logic             clamped;
    } pdc_out_t;

    // gain set
    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
    } pdc_gains_t;

    // error, saturated sum and difference of one sample
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  err_sum;
        logic signed [DIFF_W-1:0] err_diff;
    } pdc_err_t;

    // the three weighted terms
    typedef struct packed {
        logic signed [PT_W-1:0] p_term;
        logic signed [IT_W-1:0] i_term;
        logic signed [DT_W-1:0] d_term;
    } pdc_terms_t;

endpackage

// ===== rtl/core/pid_dac_controller_core.sv =====
// pid_dac_controller_core: top level of the pid controller with clamped dac output
// instantiates pdc_error_stage, pdc_term_mult, pdc_term_sum, pdc_out_clamp; uses pdc_pkg
//
// usage
//   s_valid/s_ready/s_payload carry one request of a reference and a measured
//   sample; m_valid/m_ready/m_payload return one dac word and a clamp flag per
//   request, in order. cfg_we/cfg_index/cfg_wdata write the proportional, integral
//   and derivative gains (signed, 24 fractional bits); an index past the last gain is
//   ignored. the user changes gains only while the pipe is empty; the block does not enforce it.
// timing
//   four register stages: error/state, gain multiply, term add, clamp/result.
//   a request passes through them in that order; one request per
//   cycle is accepted when results are taken as they appear. the three
//   multiplies of the 32-bit gains sit in one stage of their own.
// reset
//   gains return to their default values, error sum and last error clear,
//   all stages empty.
// stall
//   each stage holds while the next is full and stalled; bubbles close up, so s_ready
//   drops only once all four stages hold requests and m_ready is low.
module pid_dac_controller_core
    import pdc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pdc_in_t              s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pdc_out_t             m_payload
);

    pdc_gains_t       gains_reg;
    logic             err_valid;
    logic             err_ready;
    pdc_err_t         err_data;
    logic             term_valid;
    logic             term_ready;
    pdc_terms_t       term_data;
    logic             acc_valid;
    logic             acc_ready;
    logic [ACC_W-1:0] acc_data;

    // gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.prop_gain  <= PROP_GAIN_RST;
            gains_reg.integ_gain <= INTEG_GAIN_RST;
            gains_reg.deriv_gain <= DERIV_GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PROP_GAIN:  gains_reg.prop_gain  <= cfg_wdata;
                REG_INTEG_GAIN: gains_reg.integ_gain <= cfg_wdata;
                REG_DERIV_GAIN: gains_reg.deriv_gain <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // error and state
    pdc_error_stage u_error_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_payload),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_data  (err_data)
    );

    // gain multiplies
    pdc_term_mult u_term_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gains     (gains_reg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_data   (err_data),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .out_data  (term_data)
    );

    // term add
    pdc_term_sum u_term_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (term_valid),
        .in_ready  (term_ready),
        .in_data   (term_data),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_acc   (acc_data)
    );

    // scale, clamp and result register
    pdc_out_clamp u_out_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .in_acc    (acc_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_payload)
    );

    // a taken request always lands in the error stage
    a_err_stage_loaded: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> err_valid
    ) else $error("request taken but error stage empty");

    // a clamped result sits exactly at one of the limits
    a_clamp_at_limit: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.clamped |->
            (m_payload.dac_word[SAMPLE_BITS-1:0] == MIN_CODE) ||
            (m_payload.dac_word[SAMPLE_BITS-1:0] == MAX_CODE)
    ) else $error("clamp flag set away from a limit");

    // control bits of the dac word are always present
    a_ctrl_bits: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.dac_word[DAC_W-1:SAMPLE_BITS] == DAC_CTRL[DAC_W-1:SAMPLE_BITS]
    ) else $error("dac control bits corrupted");

    // a full accumulator stage with a free result register moves on
    a_acc_drains: assert property (
        @(posedge aclk) disable iff (!aresetn)
        acc_valid && !m_valid |=> m_valid
    ) else $error("accumulator stage failed to advance");

endmodule

// ===== rtl/core/pdc_error_stage.sv =====
// pdc_error_stage: error, saturating error sum and error difference
// holds the controller state; uses pdc_pkg
module pdc_error_stage
    import pdc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  pdc_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pdc_err_t out_data
);

    logic                     valid_reg;
    pdc_err_t                 data_reg;
    pdc_err_t                 data_next;
    logic signed [ERR_W-1:0]  last_err_reg;
    logic signed [SUM_W-1:0]  err_sum_reg;
    logic signed [SUM_W:0]    sum_wide;
    logic                     accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // error terms of the incoming request
    always_comb begin
        data_next.err = $signed({1'b0, in_data.ref_sample})
                      - $signed({1'b0, in_data.meas_sample});
        data_next.err_diff = {data_next.err[ERR_W-1], data_next.err}
                           - {last_err_reg[ERR_W-1], last_err_reg};
        sum_wide = {err_sum_reg[SUM_W-1], err_sum_reg}
                 + {{(SUM_W+1-ERR_W){data_next.err[ERR_W-1]}}, data_next.err};
        // saturate when the two top bits disagree
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            data_next.err_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            data_next.err_sum = sum_wide[SUM_W-1:0];
        end
    end

    // state and stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            last_err_reg <= '0;
            err_sum_reg  <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept) begin
                last_err_reg <= data_next.err;
                err_sum_reg  <= data_next.err_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/pdc_term_mult.sv =====
// pdc_term_mult: the three gain multiplies, one registered stage
// uses pdc_pkg
module pdc_term_mult
    import pdc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pdc_gains_t gains,
    input  logic       in_valid,
    output logic       in_ready,
    input  pdc_err_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pdc_terms_t out_data
);

    logic       valid_reg;
    pdc_terms_t data_reg;
    pdc_terms_t data_next;
    logic       accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // signed products at full width
    always_comb begin
        data_next.p_term = PT_W'($signed(gains.prop_gain))  * PT_W'($signed(in_data.err));
        data_next.i_term = IT_W'($signed(gains.integ_gain)) * IT_W'($signed(in_data.err_sum));
        data_next.d_term = DT_W'($signed(gains.deriv_gain)) * DT_W'($signed(in_data.err_diff));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/pdc_term_sum.sv =====
// pdc_term_sum: adds the three weighted terms into the accumulator
// uses pdc_pkg
module pdc_term_sum
    import pdc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdc_terms_t        in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ACC_W-1:0]  out_acc
);

    logic             valid_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic             accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;

    // sign-extended three-input add; the integral term already spans the accumulator
    always_comb begin
        acc_next = {{(ACC_W-PT_W){in_data.p_term[PT_W-1]}}, in_data.p_term}
                 + in_data.i_term
                 + {{(ACC_W-DT_W){in_data.d_term[DT_W-1]}}, in_data.d_term};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== rtl/core/pdc_out_clamp.sv =====
// pdc_out_clamp: scales the accumulator, adds mid-scale, clamps, builds the dac word
// holds the result register; uses pdc_pkg
module pdc_out_clamp
    import pdc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ACC_W-1:0] in_acc,
    output logic             out_valid,
    input  logic             out_ready,
    output pdc_out_t         out_data
);

    logic                   valid_reg;
    pdc_out_t               data_reg;
    pdc_out_t               data_next;
    logic [DRV_W-1:0]       drive;
    logic [SAMPLE_BITS-1:0] code;
    logic                   accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // floor shift is a plain bit select of the two's complement value
    always_comb begin
        drive = {in_acc[ACC_W-1], in_acc[ACC_W-1:GAIN_FRAC_BITS]} + MID_SCALE;
        data_next.clamped = 1'b0;
        if (drive[DRV_W-1]) begin
            code              = MIN_CODE;
            data_next.clamped = 1'b1;
        end else if (|drive[DRV_W-2:SAMPLE_BITS]) begin
            code              = MAX_CODE;
            data_next.clamped = 1'b1;
        end else begin
            code = drive[SAMPLE_BITS-1:0];
        end
        data_next.dac_word = DAC_CTRL + DAC_W'(code);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

endmodule
